// ===== hdl/hkse_pkg.sv =====
// Shared types, codes and key masks for the hashed key set engine.
// No dependencies; imported by every module of the block but hkse_way_ram.
package hkse_pkg;

  localparam int unsigned HEAD_W     = 32;
  localparam int unsigned TAIL_W     = 64;
  localparam int unsigned ENTRY_W    = 1 + HEAD_W + TAIL_W;
  localparam int unsigned HASH_W     = 26;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] STATUS_ABSENT   = 2'd0;
  localparam logic [1:0] STATUS_PRESENT  = 2'd1;
  localparam logic [1:0] STATUS_INSERTED = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  localparam logic [HEAD_W-1:0] HEAD_MASK [4] = '{
    32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF
  };
  localparam logic [TAIL_W-1:0] TAIL_MASK [4] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_0000_0000_0000,
    64'hFFFF_FFFF_FF00_0000, 64'hFFFF_FFFF_FFFF_FFFF
  };

  typedef struct packed {
    logic              go;
    logic [1:0]        level;
    logic [HEAD_W-1:0] head;
    logic [TAIL_W-1:0] tail;
  } hash_req_t;

endpackage

// ===== hdl/hkse_hash.sv =====
// Bucket hash: key fold or upper head bits, modulo by the bucket count through
// reciprocal multiplication. Uses hkse_pkg; one shared multiplier, two passes.
module hkse_hash #(
  parameter int unsigned BUCKET_COUNT = 4093,
  parameter int unsigned REM_W        = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hkse_pkg::hash_req_t req_i,
  output logic                done_o,
  output logic [REM_W-1:0]    bucket_o
);
  import hkse_pkg::*;

  // exact quotient for any HASH_W-bit value: 2^REM_W >= BUCKET_COUNT
  localparam int unsigned SHIFT   = HASH_W + REM_W;
  localparam int unsigned RECIP_W = HASH_W + 2;
  localparam int unsigned PROD_W  = HASH_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT));

  logic [HASH_W-1:0]  val_q, val_d;
  logic [HASH_W-1:0]  quo_q, quo_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic               step_q, step_d;
  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [HASH_W-1:0]  mul_a;
  logic [RECIP_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  function automatic logic [HASH_W-1:0] fold_key(logic [HEAD_W-1:0] head,
                                                 logic [TAIL_W-1:0] tail);
    logic [HEAD_W+TAIL_W-1:0] k;
    logic [HASH_W-1:0]        y;
    k = {head, tail};
    y = '0;
    for (int i = 0; i < 12; i++) begin
      y = y ^ (HASH_W'(k[HEAD_W+TAIL_W-1-8*i -: 8]) << ((i % 4) * 6));
    end
    return y;
  endfunction

  // pass 0: quotient = val * RECIP >> SHIFT; pass 1: quotient * BUCKET_COUNT
  assign mul_a = step_q ? quo_q : val_q;
  assign mul_b = step_q ? RECIP_W'(BUCKET_COUNT) : RECIP;
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    val_d  = val_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.go) begin
      val_d  = (req_i.level == 2'd0) ? HASH_W'(req_i.head[HEAD_W-1:8])
                                     : fold_key(req_i.head, req_i.tail);
      step_d = 1'b0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (!step_q) begin
        quo_d  = HASH_W'(prod >> SHIFT);
        step_d = 1'b1;
      end else begin
        rem_d  = REM_W'(val_q - HASH_W'(prod));
        step_d = 1'b0;
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q;

endmodule

// ===== hdl/hkse_way_ram.sv =====
// One way of the bucket store: one write port, one registered read port.
// No dependencies.
module hkse_way_ram #(
  parameter int unsigned DEPTH  = 16372,
  parameter int unsigned ADDR_W = 14,
  parameter int unsigned DATA_W = 97
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/hashed_key_set_engine.sv =====
// Top level of the hashed key set engine: sequencer, bucket store, hash unit.
// Uses hkse_pkg, hkse_hash and hkse_way_ram.
//
// Usage:
//   An item (opcode_i, level_i, key_high_i, key_low_i) is taken at a rising
//   edge with start high and busy low. Each item gives one status beat on
//   status_o, marked by status_valid_o for one cycle; it cannot be held off.
//   For a valid level the status beat follows the quotient and remainder
//   passes of the reciprocal-multiply modulo in the hash unit, one bucket
//   read with all ways compared at once, and the write-back with the
//   status. busy drops as the beat shows, so a new item is taken only
//   once the last one has given its beat. A level at or above LEVELS
//   answers in the cycle after it is taken, and busy stays low.
//   Reset: the block runs a clearing pass over all LEVELS*BUCKET_COUNT
//   bucket rows, one row per cycle, with busy high, before it takes the
//   first item.
//   Status: 0 absent, 1 present, 2 newly inserted, 3 bucket full (dropped).
module hashed_key_set_engine #(
  parameter int unsigned BUCKET_COUNT = 4093,
  parameter int unsigned WAYS         = 4,
  parameter int unsigned LEVELS       = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [1:0]  level_i,
  input  logic [31:0] key_high_i,
  input  logic [63:0] key_low_i,
  output logic [1:0]  status_o,
  output logic        status_valid_o
);
  import hkse_pkg::*;

  localparam int unsigned ROWS  = LEVELS * BUCKET_COUNT;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned REM_W = $clog2(BUCKET_COUNT + 1);
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_HASH  = 2'd2;
  localparam logic [1:0] S_CMP   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [ROW_W-1:0]  clr_q, clr_d;
  logic [ROW_W-1:0]  row_q, row_calc;
  logic              op_q;
  logic [1:0]        level_q;
  logic [HEAD_W-1:0] head_q, head_in;
  logic [TAIL_W-1:0] tail_q, tail_in;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q, status_d;
  logic              level_ok;
  logic              accept;

  hash_req_t         hash_req;
  logic              hash_done;
  logic [REM_W-1:0]  bucket;

  logic [WAYS-1:0]    way_we;
  logic [ROW_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata [WAYS];
  logic               hit;
  logic               have_free;
  logic [WAY_W-1:0]   free_way;

  assign level_ok = ({1'b0, level_i} < 3'(LEVELS));
  assign accept   = start && (state_q == S_IDLE);
  assign head_in  = key_high_i & HEAD_MASK[level_i];
  assign tail_in  = key_low_i & TAIL_MASK[level_i];

  assign hash_req.go    = accept && level_ok;
  assign hash_req.level = level_i;
  assign hash_req.head  = head_in;
  assign hash_req.tail  = tail_in;

  hkse_hash #(
    .BUCKET_COUNT(BUCKET_COUNT),
    .REM_W       (REM_W)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (hash_req),
    .done_o  (hash_done),
    .bucket_o(bucket)
  );

  assign row_calc = ROW_W'(32'(level_q) * BUCKET_COUNT + 32'(bucket));

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    hkse_way_ram #(
      .DEPTH (ROWS),
      .ADDR_W(ROW_W),
      .DATA_W(ENTRY_W)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (way_we[w]),
      .waddr_i(waddr),
      .wdata_i(wdata),
      .raddr_i(row_calc),
      .rdata_o(rdata[w])
    );
  end

  always_comb begin
    hit       = 1'b0;
    have_free = 1'b0;
    free_way  = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!rdata[w][ENTRY_W-1]) begin
        have_free = 1'b1;
        free_way  = WAY_W'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (rdata[w][ENTRY_W-1] && (rdata[w][ENTRY_W-2:0] == {head_q, tail_q})) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = 1'b0;
    status_d    = status_q;
    way_we      = '0;
    waddr       = row_q;
    wdata       = {1'b1, head_q, tail_q};
    unique case (state_q)
      S_CLEAR: begin
        way_we = '1;
        waddr  = clr_q;
        wdata  = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == ROW_W'(ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (level_ok) begin
            state_d = S_HASH;
          end else begin
            out_valid_d = 1'b1;
            status_d    = (opcode_i == OP_LOOKUP) ? STATUS_ABSENT : STATUS_FULL;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
        if (hit) begin
          status_d = STATUS_PRESENT;
        end else if (op_q == OP_LOOKUP) begin
          status_d = STATUS_ABSENT;
        end else if (!have_free) begin
          status_d = STATUS_FULL;
        end else begin
          status_d = STATUS_INSERTED;
          for (int w = 0; w < WAYS; w++) begin
            way_we[w] = (free_way == WAY_W'(w));
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (hash_req.go) begin
      op_q    <= opcode_i;
      level_q <= level_i;
      head_q  <= head_in;
      tail_q  <= tail_in;
    end
    if (state_q == S_HASH && hash_done) begin
      row_q <= row_calc;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign status_o       = status_q;
  assign status_valid_o = out_valid_q;

endmodule

// ===== hdl/hkse_checker.sv =====
// Port-level checks for the hashed key set engine, bound to the top level.
// Uses hkse_pkg; watches only the top-level ports.
module hkse_checker #(
  parameter int unsigned LEVELS = 4
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       opcode_i,
  input logic [1:0] level_i,
  input logic [1:0] status_o,
  input logic       status_valid_o
);
  import hkse_pkg::*;

  logic lvl_ok;
  assign lvl_ok = ({1'b0, level_i} < 3'(LEVELS));

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && lvl_ok) |=> busy)
    else $error("valid-level beat did not raise busy");

  a_bad_level_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !lvl_ok) |=> (status_valid_o &&
      (status_o == ($past(opcode_i) ? STATUS_ABSENT : STATUS_FULL))))
    else $error("bad-level beat answered wrongly");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_valid_o && $past(busy)) |-> !busy)
    else $error("result beat while still busy");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_valid_o && !$past(busy)) |-> $past(start && !lvl_ok))
    else $error("result beat without a cause");

endmodule

bind hashed_key_set_engine hkse_checker #(.LEVELS(LEVELS)) u_hkse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .opcode_i      (opcode_i),
  .level_i       (level_i),
  .status_o      (status_o),
  .status_valid_o(status_valid_o)
);
